// File: sv/lpb_pkg.sv
package lpb_pkg;

  localparam int NUM_LEDS     = 4;
  localparam int PATTERN_BITS = 32;
  localparam int LED_IDX_W    = 2;
  localparam int PATTERN_W    = 32;
  localparam int PERIOD_W     = 16;
  localparam int BITS_LEFT_W  = $clog2(PATTERN_BITS + 1);
  localparam int LED_OUT_W    = 4;

  typedef enum logic [0:0] {
    CMD_TICK = 1'b0,
    CMD_LOAD = 1'b1
  } lpb_cmd_t;

  typedef struct packed {
    lpb_cmd_t               cmd;
    logic [LED_IDX_W-1:0]   led_index;
    logic [PATTERN_W-1:0]   pattern;
    logic [PERIOD_W-1:0]    period_ticks;
  } lpb_in_t;

  typedef struct packed {
    logic [LED_OUT_W-1:0] led_levels;
    logic [LED_OUT_W-1:0] led_updated;
  } lpb_out_t;

  typedef struct packed {
    logic tick;
    logic load;
  } lpb_ch_ctrl_t;

endpackage

// File: sv/led_pattern_blinker_unit.sv
// led pattern blinker: four channels, each plays a 32-bit on/off pattern lsb first
// input channel in_valid / in_ready / in_data carries one item: a tick (cmd = tick)
//   steps every channel, a load (cmd = load) sets pattern and period of one channel
//   and restarts it, so bit 0 shows for one extra period at the start
// result channel out_valid / out_ready / out_data gives exactly one item per input
//   item: current led levels and, for a tick, which channels were driven
// path: an accepted item is held in the input register, and its result is captured in the
//   output register once that register is empty or being read
// throughput: one item per cycle while out_ready stays high; all channels update in
//   parallel counters in the cycle the item leaves the input register
// stall: while out_ready is low the result holds; one more item is still taken
//   into the input register, after which in_ready drops until the result is taken
// reset (rst_n low, synchronous): all leds off, patterns and periods cleared,
//   countdowns and bit counts at one, both registers empty
module led_pattern_blinker_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  lpb_pkg::lpb_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lpb_pkg::lpb_out_t out_data
);

  logic             s1_valid_r, s1_valid_nxt;
  lpb_pkg::lpb_in_t s1_item_r;
  logic             s1_adv;
  logic             out_valid_r, out_valid_nxt;
  lpb_pkg::lpb_out_t out_data_r;
  lpb_pkg::lpb_out_t result;

  logic [lpb_pkg::NUM_LEDS-1:0] lvl_cur;
  logic [lpb_pkg::NUM_LEDS-1:0] lvl_nxt;
  logic [lpb_pkg::NUM_LEDS-1:0] upd;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_valid && in_ready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= result;
    end
  end

  for (genvar i = 0; i < lpb_pkg::NUM_LEDS; i++) begin : g_ch
    lpb_pkg::lpb_ch_ctrl_t ctrl;

    assign ctrl.tick = s1_adv && (s1_item_r.cmd == lpb_pkg::CMD_TICK);
    assign ctrl.load = s1_adv && (s1_item_r.cmd == lpb_pkg::CMD_LOAD)
                       && (s1_item_r.led_index == lpb_pkg::LED_IDX_W'(i));

    lpb_channel u_ch (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctrl         (ctrl),
      .pattern      (s1_item_r.pattern),
      .period_ticks (s1_item_r.period_ticks),
      .level        (lvl_cur[i]),
      .level_nxt    (lvl_nxt[i]),
      .updated      (upd[i])
    );
  end

  always_comb begin
    result = '0;
    for (int i = 0; i < lpb_pkg::NUM_LEDS && i < lpb_pkg::LED_OUT_W; i++) begin
      result.led_levels[i]  = lvl_nxt[i];
      result.led_updated[i] = upd[i];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a load drives no channel and leaves the levels as they were
  a_load_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_item_r.cmd == lpb_pkg::CMD_LOAD) |=> out_data_r.led_updated == '0)
    else $error("load item reported a driven channel");

  a_load_keeps_levels: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && (s1_item_r.cmd == lpb_pkg::CMD_LOAD)
    |=> out_data_r.led_levels == $past(lvl_cur[lpb_pkg::LED_OUT_W-1:0]))
    else $error("load item changed led levels");

  // a channel level only moves when that channel is driven by a tick
  a_level_needs_update: assert property (@(posedge clk) disable iff (!rst_n)
    (lvl_nxt != lvl_cur) |-> s1_adv && (s1_item_r.cmd == lpb_pkg::CMD_TICK) && (upd != '0))
    else $error("led level changed without a tick");

  a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled with room to spare");

endmodule

// File: sv/lpb_channel.sv
module lpb_channel (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lpb_pkg::lpb_ch_ctrl_t          ctrl,
  input  logic [lpb_pkg::PATTERN_W-1:0]  pattern,
  input  logic [lpb_pkg::PERIOD_W-1:0]   period_ticks,
  output logic                           level,
  output logic                           level_nxt,
  output logic                           updated
);

  logic [lpb_pkg::PATTERN_W-1:0]   store_r, store_nxt;
  logic [lpb_pkg::PATTERN_W-1:0]   shift_r, shift_nxt;
  logic [lpb_pkg::PERIOD_W-1:0]    reload_r, reload_nxt;
  logic [lpb_pkg::PERIOD_W-1:0]    cnt_r, cnt_nxt;
  logic [lpb_pkg::PERIOD_W-1:0]    cnt_dec;
  logic [lpb_pkg::BITS_LEFT_W-1:0] bits_r, bits_nxt;
  logic                            level_r;
  logic                            hit;

  assign cnt_dec = cnt_r - lpb_pkg::PERIOD_W'(1);
  assign hit     = (cnt_dec == '0);
  assign updated = ctrl.tick && hit;

  always_comb begin
    store_nxt  = store_r;
    shift_nxt  = shift_r;
    reload_nxt = reload_r;
    cnt_nxt    = cnt_r;
    bits_nxt   = bits_r;
    level_nxt  = level_r;
    if (ctrl.load) begin
      store_nxt  = pattern;
      shift_nxt  = pattern;
      reload_nxt = period_ticks;
      cnt_nxt    = lpb_pkg::PERIOD_W'(1);
      bits_nxt   = lpb_pkg::BITS_LEFT_W'(1);
    end else if (ctrl.tick) begin
      if (hit) begin
        cnt_nxt   = reload_r;
        level_nxt = shift_r[0];
        if (bits_r <= lpb_pkg::BITS_LEFT_W'(1)) begin
          bits_nxt  = lpb_pkg::BITS_LEFT_W'(lpb_pkg::PATTERN_BITS);
          shift_nxt = store_r;
        end else begin
          bits_nxt  = bits_r - lpb_pkg::BITS_LEFT_W'(1);
          shift_nxt = shift_r >> 1;
        end
      end else begin
        cnt_nxt = cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r  <= '0;
      shift_r  <= '0;
      reload_r <= '0;
      cnt_r    <= lpb_pkg::PERIOD_W'(1);
      bits_r   <= lpb_pkg::BITS_LEFT_W'(1);
      level_r  <= 1'b0;
    end else begin
      store_r  <= store_nxt;
      shift_r  <= shift_nxt;
      reload_r <= reload_nxt;
      cnt_r    <= cnt_nxt;
      bits_r   <= bits_nxt;
      level_r  <= level_nxt;
    end
  end

  assign level = level_r;

endmodule

// File: tb/led_level_checker.sv
`timescale 1ns / 1ps

module led_level_checker
  import lpb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_ready,
  input  lpb_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_ready,
  input  lpb_out_t out_data,
  output int       fail_count,
  output int       pending
);

  logic [PATTERN_W-1:0]   pat_store  [NUM_LEDS];
  logic [PATTERN_W-1:0]   shift_pat  [NUM_LEDS];
  logic [PERIOD_W-1:0]    reload_val [NUM_LEDS];
  logic [PERIOD_W-1:0]    countdown  [NUM_LEDS];
  logic [BITS_LEFT_W-1:0] bits_left  [NUM_LEDS];
  logic                   lvl        [NUM_LEDS];

  lpb_out_t levels_due[$];
  lpb_out_t want;
  int       errors;

  // one item through the channel state, returns the levels it leaves behind and the channels it drove
  function automatic lpb_out_t advance_channels(lpb_in_t it);
    lpb_out_t res;
    int       ch;
    res = '0;
    if (it.cmd == CMD_LOAD) begin
      ch = int'(it.led_index) % NUM_LEDS;
      pat_store[ch]  = it.pattern;
      shift_pat[ch]  = it.pattern;
      reload_val[ch] = it.period_ticks;
      countdown[ch]  = PERIOD_W'(1);
      bits_left[ch]  = BITS_LEFT_W'(1);
    end else begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        countdown[i] = countdown[i] - 1'b1;
        if (countdown[i] == 0) begin
          countdown[i] = reload_val[i];
          lvl[i]       = shift_pat[i][0];
          if (i < LED_OUT_W) res.led_updated[i] = 1'b1;
          shift_pat[i] = shift_pat[i] >> 1;
          if (bits_left[i] <= 1) begin
            bits_left[i] = BITS_LEFT_W'(PATTERN_BITS);
            shift_pat[i] = pat_store[i];
          end else begin
            bits_left[i] = bits_left[i] - 1'b1;
          end
        end
      end
    end
    for (int i = 0; i < NUM_LEDS && i < LED_OUT_W; i++) res.led_levels[i] = lvl[i];
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEDS; i++) begin
        pat_store[i]  = '0;
        shift_pat[i]  = '0;
        reload_val[i] = '0;
        countdown[i]  = PERIOD_W'(1);
        bits_left[i]  = BITS_LEFT_W'(1);
        lvl[i]        = 1'b0;
      end
      levels_due.delete();
    end else begin
      // results first: an item taken at this edge cannot have its result here
      if (out_valid && out_ready) begin
        if (levels_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t unexpected item: levels %h updated %h", $realtime,
                     out_data.led_levels, out_data.led_updated);
        end else begin
          want = levels_due.pop_front();
          if (want.led_levels !== out_data.led_levels ||
              want.led_updated !== out_data.led_updated) begin
            errors++;
            if (errors <= 10)
              $display("%0t mismatch: levels exp %h got %h, updated exp %h got %h",
                       $realtime, want.led_levels, out_data.led_levels,
                       want.led_updated, out_data.led_updated);
          end
        end
      end
      if (in_valid && in_ready) levels_due.push_back(advance_channels(in_data));
    end
    pending    <= levels_due.size();
    fail_count <= errors;
  end

endmodule

// File: tb/led_pattern_blinker_unit_tb.sv
`timescale 1ns / 1ps

module led_pattern_blinker_unit_tb;
  import lpb_pkg::*;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  lpb_in_t  in_data;
  logic     out_valid;
  logic     out_ready;
  lpb_out_t out_data;
  int       fail_count;
  int       pending;

  logic     hurry = 1'b0;
  logic     send_quiet = 1'b0;
  int       sent;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  led_pattern_blinker_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  led_level_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  function automatic lpb_in_t tick_item();
    lpb_in_t it;
    it.cmd          = CMD_TICK;
    it.led_index    = LED_IDX_W'($urandom);
    it.pattern      = PATTERN_W'($urandom);
    it.period_ticks = PERIOD_W'($urandom);
    return it;
  endfunction

  function automatic lpb_in_t load_item(int idx, logic [PATTERN_W-1:0] pat,
                                        logic [PERIOD_W-1:0] per);
    lpb_in_t it;
    it.cmd          = CMD_LOAD;
    it.led_index    = LED_IDX_W'(idx);
    it.pattern      = pat;
    it.period_ticks = per;
    return it;
  endfunction

  function automatic lpb_in_t random_item();
    lpb_in_t it;
    int      pick;
    it = tick_item();
    if ($urandom_range(0, 99) < 15) begin
      it.cmd = CMD_LOAD;
      pick = $urandom_range(0, 9);
      // mostly short periods so patterns wrap within the run
      if (pick < 7) it.period_ticks = PERIOD_W'($urandom_range(1, 6));
      else if (pick == 7) it.period_ticks = '0;
      else if (pick == 8) it.period_ticks = PERIOD_W'($urandom_range(7, 40));
      pick = $urandom_range(0, 9);
      if (pick == 0) it.pattern = '0;
      else if (pick == 1) it.pattern = '1;
    end
    return it;
  endfunction

  task automatic offer(input lpb_in_t it);
    int gap;
    gap = (hurry || send_quiet) ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!(in_valid && in_ready));
    sent++;
    if (sent % 64 == 0) send_quiet = ($urandom_range(0, 3) == 0);
  endtask

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int gap;
    int taken;
    logic quiet;
    taken = 0;
    quiet = 1'b0;
    forever begin
      if (taken % 64 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (taken == 400) gap = 300;
      else if (quiet || hurry) gap = 0;
      else gap = $urandom_range(0, 18);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  initial begin
    int settle;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // from reset, then extremes of pattern, period and index
    offer(tick_item());
    offer(load_item(0, 32'hFFFF_FFFF, 16'd1));
    offer(load_item(1, 32'hAAAA_AAAA, 16'd2));
    offer(load_item(2, 32'h8000_0001, 16'hFFFF));
    offer(load_item(3, 32'h5555_5555, 16'd0));
    repeat (6) offer(tick_item());
    offer(load_item(2, 32'h0000_0000, 16'd1));
    offer(load_item(3, 32'h0000_0003, 16'd1));
    repeat (10) offer(tick_item());

    repeat (1100) offer(random_item());

    // back to back, long and short periods side by side
    hurry = 1'b1;
    offer(load_item(0, PATTERN_W'($urandom), 16'd0));
    offer(load_item(1, 32'hF0F0_F0F0, 16'hFFFF));
    offer(load_item(2, 32'hFFFF_FFFF, 16'd1));
    offer(load_item(3, 32'h0000_0001, 16'd2));
    repeat (23) offer(tick_item());
    hurry = 1'b0;
    in_valid <= 1'b0;

    settle = 0;
    while (pending != 0 && settle < 2000) begin
      @(posedge clk);
      settle++;
    end
    repeat (10) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("led_pattern_blinker_unit regression: pass");
    end else begin
      $display("led_pattern_blinker_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("led_pattern_blinker_unit regression: fail");
    $finish;
  end

endmodule
